// ===== src/ipjq_pkg.sv =====
// shared constants, codes and item types of the indexed priority job queue
package ipjq_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int KEY_DEPTH  = 96;
    localparam int MODEL_BITS = 8;
    localparam int NODE_BITS  = 32;
    localparam int PRIO_BITS  = 32;
    localparam int FUNC_BITS  = 3;
    localparam int MODE_BITS  = 2;
    localparam int STAT_BITS  = 2;
    localparam int SLOT_BITS  = $clog2(HEAP_DEPTH);
    localparam int SIZE_BITS  = $clog2(HEAP_DEPTH + 1);

    localparam logic [FUNC_BITS-1:0] FUNC_PUSH     = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_TAKE     = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_COMPLETE = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_UPDATE   = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_ABORT    = 3'd4;
    localparam logic [FUNC_BITS-1:0] FUNC_QUERY    = 3'd5;

    localparam logic [MODE_BITS-1:0] MODE_NEVER = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_ANY   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_DEC   = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_INC   = 2'd3;

    localparam logic [STAT_BITS-1:0] STAT_NONE    = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_LOADING = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_WAITING = 2'd2;

    typedef struct packed {
        logic [FUNC_BITS-1:0]        func;
        logic [MODEL_BITS-1:0]       model_id;
        logic [NODE_BITS-1:0]        node_id;
        logic signed [PRIO_BITS-1:0] priority_req;
    } t_item;

    typedef struct packed {
        logic                        done_flag;
        logic                        job_valid;
        logic [MODEL_BITS-1:0]       job_model;
        logic [NODE_BITS-1:0]        job_node;
        logic signed [PRIO_BITS-1:0] job_priority;
        logic [STAT_BITS-1:0]        index_status;
        logic [SIZE_BITS-1:0]        job_count;
    } t_result;

    typedef struct packed {
        logic [MODEL_BITS-1:0] model;
        logic [NODE_BITS-1:0]  node;
        logic [SLOT_BITS-1:0]  slot;
    } t_key_ent;

endpackage

// ===== src/indexed_priority_job_queue_core.sv =====
// indexed max-priority job queue: key store scan, heap memory and sift sequencer
//
//   channel   ports                          direction  handshake
//   command   start, busy, i_item            in         taken when start && !busy
//   result    o_done, o_result               out        one-cycle strobe, no stall
//   config    i_cfg_we, i_cfg_wdata          in         written when i_cfg_we
//
// an item first scans the whole key store and checks the key's status, then a
// sift walks the heap level by level (abort may walk up and then down); the scan
// of the single-port key memory takes the larger share of that work. busy is
// high from the item's acceptance until its result strobe. reset is synchronous
// and needs no clearing pass; the receiver cannot stall and each result shows
// for exactly one cycle.
module indexed_priority_job_queue_core #(
    parameter int KEY_DEPTH = ipjq_pkg::KEY_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ipjq_pkg::t_item                     i_item,
    output logic                                o_done,
    output ipjq_pkg::t_result                   o_result,
    input  logic                                i_cfg_we,
    input  logic [ipjq_pkg::MODE_BITS-1:0]      i_cfg_wdata
);

    localparam int KW  = $clog2(KEY_DEPTH);
    localparam int KCW = $clog2(KEY_DEPTH + 1);
    localparam int HW  = ipjq_pkg::SLOT_BITS;
    localparam int SW  = ipjq_pkg::SIZE_BITS;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_UP_RD  = 4'd3;
    localparam logic [3:0] S_UP_CMP = 4'd4;
    localparam logic [3:0] S_DN_RD  = 4'd5;
    localparam logic [3:0] S_DN_CMP = 4'd6;
    localparam logic [3:0] S_DN_LD  = 4'd7;
    localparam logic [3:0] S_DN_LD2 = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    typedef struct packed {
        logic [ipjq_pkg::MODEL_BITS-1:0]       model;
        logic [ipjq_pkg::NODE_BITS-1:0]        node;
        logic signed [ipjq_pkg::PRIO_BITS-1:0] prio;
        logic [KW-1:0]                         key;
    } t_heap_ent;

    // control and payload registers
    logic [3:0]                        r_state, n_state;
    logic [KCW-1:0]                    r_cnt, n_cnt;
    logic                              r_cmp_v, n_cmp_v;
    logic [KW-1:0]                     r_cmp_idx, n_cmp_idx;
    logic                              r_fnd, n_fnd;
    logic [KW-1:0]                     r_kidx, n_kidx;
    logic [HW-1:0]                     r_kslot, n_kslot;
    logic                              r_free_v, n_free_v;
    logic [KW-1:0]                     r_free_idx, n_free_idx;
    logic [SW-1:0]                     r_size, n_size;
    logic [HW-1:0]                     r_pos, n_pos;
    logic [HW-1:0]                     r_s0, n_s0;
    logic                              r_then_dn, n_then_dn;
    t_heap_ent                         r_ent, n_ent;
    ipjq_pkg::t_item                   r_req, n_req;
    ipjq_pkg::t_result                 r_res, n_res;
    logic                              r_done, n_done;
    logic [KEY_DEPTH-1:0]              r_key_vld, n_key_vld;
    logic [KEY_DEPTH-1:0]              r_key_pend, n_key_pend;
    logic [ipjq_pkg::MODE_BITS-1:0]    r_mode;

    // key memory
    ipjq_pkg::t_key_ent                r_key_mem [KEY_DEPTH];
    ipjq_pkg::t_key_ent                r_key_rd;
    logic [KW-1:0]                     key_raddr;
    logic [KW-1:0]                     key_waddr;
    logic                              key_we_id;
    logic                              key_we_slot;
    logic [HW-1:0]                     key_wslot;

    // heap memory ports
    logic                              heap_we;
    logic [HW-1:0]                     heap_waddr;
    t_heap_ent                         heap_wdata;
    logic [HW-1:0]                     heap_ra, heap_rb;
    logic [$bits(t_heap_ent)-1:0]      heap_da_raw, heap_db_raw;
    t_heap_ent                         heap_da, heap_db;

    // decision terms
    logic                              waiting;
    logic                              eligible;
    logic                              mode_ok;
    logic [HW+1:0]                     child_l, child_r;
    logic [HW+1:0]                     size_x;
    logic                              left_gt;
    logic                              take_l, take_r;
    logic [HW-1:0]                     parent;
    logic [HW-1:0]                     last_slot;

    ipjq_heap_ram #(
        .DEPTH (ipjq_pkg::HEAP_DEPTH),
        .WIDTH ($bits(t_heap_ent))
    ) u_heap (
        .i_clk     (i_clk),
        .i_we      (heap_we),
        .i_waddr   (heap_waddr),
        .i_wdata   (heap_wdata),
        .i_raddr_a (heap_ra),
        .i_raddr_b (heap_rb),
        .o_rdata_a (heap_da_raw),
        .o_rdata_b (heap_db_raw)
    );

    assign heap_da = t_heap_ent'(heap_da_raw);
    assign heap_db = t_heap_ent'(heap_db_raw);

    always_ff @(posedge i_clk) begin
        if (key_we_id) begin
            r_key_mem[key_waddr].model <= r_req.model_id;
            r_key_mem[key_waddr].node  <= r_req.node_id;
        end
        if (key_we_slot) begin
            r_key_mem[key_waddr].slot <= key_wslot;
        end
        r_key_rd <= r_key_mem[key_raddr];
    end

    assign mode_ok   = (r_mode != ipjq_pkg::MODE_NEVER);
    assign waiting   = r_fnd && ({1'b0, r_kslot} < r_size) && (heap_da.key == r_kidx);
    assign eligible  = mode_ok && r_fnd && !r_key_pend[r_kidx] && waiting;
    assign last_slot = HW'(r_size - SW'(1));
    assign parent    = HW'((r_pos - HW'(1)) >> 1);
    assign child_l   = {1'b0, r_pos, 1'b1};
    assign child_r   = child_l + (HW+2)'(1);
    assign size_x    = {1'b0, r_size};
    assign left_gt   = $signed(heap_db.prio) < $signed(heap_da.prio);

    // child selection mirrors the two-child / one-child cases of sift down
    always_comb begin
        take_l = 1'b0;
        take_r = 1'b0;
        if (child_r < size_x) begin
            if (left_gt && ($signed(r_ent.prio) < $signed(heap_da.prio))) begin
                take_l = 1'b1;
            end else if (!left_gt && ($signed(r_ent.prio) < $signed(heap_db.prio))) begin
                take_r = 1'b1;
            end
        end else if (child_l < size_x) begin
            take_l = ($signed(r_ent.prio) < $signed(heap_da.prio));
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_cmp_v    = 1'b0;
        n_cmp_idx  = r_cmp_idx;
        n_fnd      = r_fnd;
        n_kidx     = r_kidx;
        n_kslot    = r_kslot;
        n_free_v   = r_free_v;
        n_free_idx = r_free_idx;
        n_size     = r_size;
        n_pos      = r_pos;
        n_s0       = r_s0;
        n_then_dn  = r_then_dn;
        n_ent      = r_ent;
        n_req      = r_req;
        n_res      = r_res;
        n_done     = 1'b0;
        n_key_vld  = r_key_vld;
        n_key_pend = r_key_pend;

        heap_we     = 1'b0;
        heap_waddr  = r_pos;
        heap_wdata  = r_ent;
        heap_ra     = r_pos;
        heap_rb     = r_pos;
        key_raddr   = r_cnt[KW-1:0];
        key_waddr   = r_ent.key;
        key_we_id   = 1'b0;
        key_we_slot = 1'b0;
        key_wslot   = r_pos;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req    = i_item;
                    n_cnt    = '0;
                    n_fnd    = 1'b0;
                    n_free_v = 1'b0;
                    n_res    = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt != KCW'(KEY_DEPTH)) begin
                    n_cmp_v   = 1'b1;
                    n_cmp_idx = r_cnt[KW-1:0];
                    n_cnt     = r_cnt + KCW'(1);
                end
                if (r_cmp_v) begin
                    if (r_key_vld[r_cmp_idx]) begin
                        if (r_key_rd.model == r_req.model_id
                                && r_key_rd.node == r_req.node_id) begin
                            n_fnd   = 1'b1;
                            n_kidx  = r_cmp_idx;
                            n_kslot = r_key_rd.slot;
                        end
                    end else if (!r_free_v) begin
                        n_free_v   = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                end
                if (r_cnt == KCW'(KEY_DEPTH) && !r_cmp_v) begin
                    // take needs top and last, the others the key's slot and last
                    if (r_req.func == ipjq_pkg::FUNC_TAKE) begin
                        heap_ra = last_slot;
                        heap_rb = '0;
                    end else begin
                        heap_ra = r_kslot;
                        heap_rb = last_slot;
                    end
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_req.func)
                    ipjq_pkg::FUNC_PUSH: begin
                        if (!r_fnd && r_free_v && r_size < SW'(ipjq_pkg::HEAP_DEPTH)) begin
                            key_we_id             = 1'b1;
                            key_waddr             = r_free_idx;
                            n_key_vld[r_free_idx]  = 1'b1;
                            n_key_pend[r_free_idx] = 1'b0;
                            n_ent.model = r_req.model_id;
                            n_ent.node  = r_req.node_id;
                            n_ent.prio  = r_req.priority_req;
                            n_ent.key   = r_free_idx;
                            n_pos       = HW'(r_size);
                            n_size      = r_size + SW'(1);
                            n_res.done_flag = 1'b1;
                            n_state     = S_UP_RD;
                        end
                    end
                    ipjq_pkg::FUNC_TAKE: begin
                        if (r_size != '0 && r_free_v) begin
                            n_res.job_valid    = 1'b1;
                            n_res.job_model    = heap_db.model;
                            n_res.job_node     = heap_db.node;
                            n_res.job_priority = heap_db.prio;
                            if (mode_ok) begin
                                n_key_pend[heap_db.key] = 1'b1;
                            end
                            n_ent   = heap_da;
                            n_pos   = '0;
                            n_size  = r_size - SW'(1);
                            n_state = S_DN_RD;
                        end
                    end
                    ipjq_pkg::FUNC_COMPLETE: begin
                        if (r_fnd && !waiting) begin
                            n_key_vld[r_kidx]  = 1'b0;
                            n_key_pend[r_kidx] = 1'b0;
                        end
                    end
                    ipjq_pkg::FUNC_UPDATE: begin
                        if (eligible) begin
                            n_ent      = heap_da;
                            n_ent.prio = r_req.priority_req;
                            n_pos      = r_kslot;
                            if ($signed(r_req.priority_req) < $signed(heap_da.prio)) begin
                                if (r_mode == ipjq_pkg::MODE_ANY
                                        || r_mode == ipjq_pkg::MODE_DEC) begin
                                    n_state = S_DN_RD;
                                end
                            end else if ($signed(r_req.priority_req)
                                    > $signed(heap_da.prio)) begin
                                if (r_mode == ipjq_pkg::MODE_ANY
                                        || r_mode == ipjq_pkg::MODE_INC) begin
                                    n_state = S_UP_RD;
                                end
                            end
                        end
                    end
                    ipjq_pkg::FUNC_ABORT: begin
                        if (eligible) begin
                            n_size             = r_size - SW'(1);
                            n_key_vld[r_kidx]  = 1'b0;
                            n_key_pend[r_kidx] = 1'b0;
                            n_res.done_flag    = 1'b1;
                            // last entry fills the hole, then walks up and down
                            if (r_kslot < last_slot) begin
                                n_ent     = heap_db;
                                n_pos     = r_kslot;
                                n_s0      = r_kslot;
                                n_then_dn = 1'b1;
                                n_state   = S_UP_RD;
                            end
                        end
                    end
                    ipjq_pkg::FUNC_QUERY: begin
                        if (r_fnd) begin
                            n_res.index_status = eligible ? ipjq_pkg::STAT_WAITING
                                                          : ipjq_pkg::STAT_LOADING;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    heap_we     = 1'b1;
                    key_we_slot = 1'b1;
                    n_then_dn   = 1'b0;
                    n_state     = r_then_dn ? S_DN_LD : S_DONE;
                end else begin
                    heap_ra = parent;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                heap_we     = 1'b1;
                key_we_slot = 1'b1;
                // equal priority still moves up
                if (!($signed(r_ent.prio) < $signed(heap_da.prio))) begin
                    heap_wdata = heap_da;
                    key_waddr  = heap_da.key;
                    n_pos      = parent;
                    n_state    = S_UP_RD;
                end else begin
                    n_then_dn = 1'b0;
                    n_state   = r_then_dn ? S_DN_LD : S_DONE;
                end
            end
            S_DN_RD: begin
                if (child_l < size_x) begin
                    heap_ra = child_l[HW-1:0];
                    heap_rb = child_r[HW-1:0];
                    n_state = S_DN_CMP;
                end else begin
                    heap_we     = 1'b1;
                    key_we_slot = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DN_CMP: begin
                heap_we     = 1'b1;
                key_we_slot = 1'b1;
                if (take_l) begin
                    heap_wdata = heap_da;
                    key_waddr  = heap_da.key;
                    n_pos      = child_l[HW-1:0];
                    n_state    = S_DN_RD;
                end else if (take_r) begin
                    heap_wdata = heap_db;
                    key_waddr  = heap_db.key;
                    n_pos      = child_r[HW-1:0];
                    n_state    = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_LD: begin
                heap_ra = r_s0;
                n_state = S_DN_LD2;
            end
            S_DN_LD2: begin
                n_ent   = heap_da;
                n_pos   = r_s0;
                n_state = S_DN_RD;
            end
            S_DONE: begin
                n_done          = 1'b1;
                n_res.job_count = r_size;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cmp_v    <= 1'b0;
            r_size     <= '0;
            r_then_dn  <= 1'b0;
            r_done     <= 1'b0;
            r_key_vld  <= '0;
            r_key_pend <= '0;
            r_mode     <= ipjq_pkg::MODE_NEVER;
        end else begin
            r_state    <= n_state;
            r_cmp_v    <= n_cmp_v;
            r_size     <= n_size;
            r_then_dn  <= n_then_dn;
            r_done     <= n_done;
            r_key_vld  <= n_key_vld;
            r_key_pend <= n_key_pend;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_cmp_idx  <= n_cmp_idx;
        r_fnd      <= n_fnd;
        r_kidx     <= n_kidx;
        r_kslot    <= n_kslot;
        r_free_v   <= n_free_v;
        r_free_idx <= n_free_idx;
        r_pos      <= n_pos;
        r_s0       <= n_s0;
        r_ent      <= n_ent;
        r_req      <= n_req;
        r_res      <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTH
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= SW'(ipjq_pkg::HEAP_DEPTH))
        else $error("heap size beyond depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    a_status_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.index_status != ipjq_pkg::STAT_NONE)
            |-> (!o_result.job_valid && !o_result.done_flag))
        else $error("query status mixed with another result");
`endif

endmodule

// ===== src/ipjq_heap_ram.sv =====
// heap entry memory: one write port, two registered read ports
module ipjq_heap_ram #(
    parameter int DEPTH = ipjq_pkg::HEAP_DEPTH,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// ===== tb/tb_indexed_priority_job_queue_core.sv =====
// testbench of the indexed priority job queue core: directed table, heap and key store fill, then random traffic
`timescale 1ns / 100ps

module tb_indexed_priority_job_queue_core;
    import ipjq_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        bit                    is_cfg;
        logic [MODE_BITS-1:0]  mode;
        t_item                 item;
        bit                    has_exp;
        t_result               exp;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_item                i_item;
    logic                 o_done;
    t_result              o_result;
    logic                 i_cfg_we;
    logic [MODE_BITS-1:0] i_cfg_wdata;

    indexed_priority_job_queue_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // queue state as predicted
    logic [MODE_BITS-1:0]  cur_mode;
    logic [MODEL_BITS-1:0] job_mdl [HEAP_DEPTH];
    logic [NODE_BITS-1:0]  job_nd  [HEAP_DEPTH];
    int                    job_pri [HEAP_DEPTH];
    int                    job_kix [HEAP_DEPTH];
    int                    job_cnt;
    bit                    key_vld [KEY_DEPTH];
    bit                    key_pnd [KEY_DEPTH];
    logic [MODEL_BITS-1:0] key_mdl [KEY_DEPTH];
    logic [NODE_BITS-1:0]  key_nd  [KEY_DEPTH];
    int                    key_pos [KEY_DEPTH];

    t_result pending_results[$];
    t_result last_pred;
    t_row    dir_rows[$];
    int      mismatches;
    int      stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int lookup_key(logic [MODEL_BITS-1:0] m, logic [NODE_BITS-1:0] n);
        for (int k = 0; k < KEY_DEPTH; k++)
            if (key_vld[k] && key_mdl[k] == m && key_nd[k] == n) return k;
        return -1;
    endfunction

    function automatic int open_key();
        for (int k = 0; k < KEY_DEPTH; k++)
            if (!key_vld[k]) return k;
        return -1;
    endfunction

    function automatic bit in_heap(int k);
        return key_pos[k] < job_cnt && job_kix[key_pos[k]] == k;
    endfunction

    function automatic void swap_jobs(int a, int b);
        logic [MODEL_BITS-1:0] tm;
        logic [NODE_BITS-1:0]  tn;
        int                    tp;
        int                    tk;
        tm = job_mdl[a]; tn = job_nd[a]; tp = job_pri[a]; tk = job_kix[a];
        job_mdl[a] = job_mdl[b]; job_nd[a] = job_nd[b];
        job_pri[a] = job_pri[b]; job_kix[a] = job_kix[b];
        job_mdl[b] = tm; job_nd[b] = tn; job_pri[b] = tp; job_kix[b] = tk;
        key_pos[job_kix[a]] = a;
        key_pos[job_kix[b]] = b;
    endfunction

    function automatic void bubble_up(int s);
        int p;
        while (s > 0) begin
            p = (s - 1) / 2;
            if (job_pri[s] < job_pri[p]) return;
            swap_jobs(s, p);
            s = p;
        end
    endfunction

    function automatic void bubble_down(int s);
        int  l;
        int  r;
        int  best;
        bit  left_big;
        forever begin
            l = s * 2 + 1;
            r = s * 2 + 2;
            best = s;
            if (r < job_cnt) begin
                left_big = job_pri[r] < job_pri[l];
                if (left_big && job_pri[s] < job_pri[l]) best = l;
                else if (!left_big && job_pri[s] < job_pri[r]) best = r;
            end else if (l < job_cnt) begin
                if (job_pri[s] < job_pri[l]) best = l;
            end
            if (best == s) return;
            swap_jobs(s, best);
            s = best;
        end
    endfunction

    function automatic t_result next_result(t_item it);
        t_result res;
        int      k;
        int      f;
        int      s;
        int      pr;
        res = '0;
        pr = it.priority_req;
        k = lookup_key(it.model_id, it.node_id);
        case (it.func)
            FUNC_PUSH: begin
                f = open_key();
                if (k < 0 && f >= 0 && job_cnt < HEAP_DEPTH) begin
                    s = job_cnt;
                    job_mdl[s] = it.model_id; job_nd[s] = it.node_id;
                    job_pri[s] = pr; job_kix[s] = f;
                    key_vld[f] = 1'b1; key_pnd[f] = 1'b0;
                    key_mdl[f] = it.model_id; key_nd[f] = it.node_id; key_pos[f] = s;
                    job_cnt = s + 1;
                    bubble_up(s);
                    res.done_flag = 1'b1;
                end
            end
            FUNC_TAKE: begin
                if (job_cnt > 0 && open_key() >= 0) begin
                    res.job_valid = 1'b1;
                    res.job_model = job_mdl[0];
                    res.job_node = job_nd[0];
                    res.job_priority = job_pri[0];
                    if (cur_mode != MODE_NEVER) key_pnd[job_kix[0]] = 1'b1;
                    swap_jobs(0, job_cnt - 1);
                    job_cnt--;
                    bubble_down(0);
                end
            end
            FUNC_COMPLETE: begin
                if (k >= 0 && !in_heap(k)) begin
                    key_vld[k] = 1'b0;
                    key_pnd[k] = 1'b0;
                end
            end
            FUNC_UPDATE: begin
                if (cur_mode != MODE_NEVER && k >= 0 && !key_pnd[k] && in_heap(k)) begin
                    s = key_pos[k];
                    if (pr < job_pri[s]) begin
                        if (cur_mode == MODE_ANY || cur_mode == MODE_DEC) begin
                            job_pri[s] = pr;
                            bubble_down(s);
                        end
                    end else if (pr > job_pri[s]) begin
                        if (cur_mode == MODE_ANY || cur_mode == MODE_INC) begin
                            job_pri[s] = pr;
                            bubble_up(s);
                        end
                    end
                end
            end
            FUNC_ABORT: begin
                if (cur_mode != MODE_NEVER && k >= 0 && !key_pnd[k] && in_heap(k)) begin
                    s = key_pos[k];
                    swap_jobs(s, job_cnt - 1);
                    job_cnt--;
                    key_vld[k] = 1'b0;
                    key_pnd[k] = 1'b0;
                    // moved entry may need to go either way
                    if (s < job_cnt) begin
                        bubble_up(s);
                        bubble_down(s);
                    end
                    res.done_flag = 1'b1;
                end
            end
            FUNC_QUERY: begin
                if (k >= 0) begin
                    res.index_status = STAT_LOADING;
                    if (cur_mode != MODE_NEVER && !key_pnd[k] && in_heap(k))
                        res.index_status = STAT_WAITING;
                end
            end
            default: ;
        endcase
        res.job_count = job_cnt[SIZE_BITS-1:0];
        return res;
    endfunction

    function automatic t_item mk_item(logic [FUNC_BITS-1:0] fn, logic [MODEL_BITS-1:0] m,
                                      logic [NODE_BITS-1:0] n, logic [PRIO_BITS-1:0] p);
        t_item it;
        it.func = fn; it.model_id = m; it.node_id = n; it.priority_req = p;
        return it;
    endfunction

    function automatic t_result mk_res(bit dn, bit jv, logic [MODEL_BITS-1:0] m,
                                       logic [NODE_BITS-1:0] n, logic [PRIO_BITS-1:0] p,
                                       logic [STAT_BITS-1:0] st, int cnt);
        t_result r;
        r.done_flag = dn; r.job_valid = jv; r.job_model = m; r.job_node = n;
        r.job_priority = p; r.index_status = st; r.job_count = cnt[SIZE_BITS-1:0];
        return r;
    endfunction

    function automatic void add_row(t_item it, bit has_exp, t_result exp);
        t_row r;
        r.is_cfg = 1'b0; r.mode = MODE_NEVER; r.item = it; r.has_exp = has_exp; r.exp = exp;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cfg(logic [MODE_BITS-1:0] mode);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1; r.mode = mode;
        dir_rows.push_back(r);
    endfunction

    task automatic wait_empty();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [MODE_BITS-1:0] mode);
        start <= 1'b0;
        wait_empty();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = mode;
    endtask

    // keeps start high after acceptance; idle lowers it
    task automatic send_item(t_item it, bit has_exp, t_result exp);
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        last_pred = next_result(it);
        pending_results.push_back(has_exp ? exp : last_pred);
    endtask

    task automatic send(t_item it);
        send_item(it, 1'b0, '0);
    endtask

    task automatic maybe_idle(bit allow);
        if (allow && $urandom_range(3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
        end
    endtask

    function automatic t_item random_item();
        int    w;
        t_item it;
        w = $urandom_range(99);
        if (w < 35) it.func = FUNC_PUSH;
        else if (w < 50) it.func = FUNC_TAKE;
        else if (w < 65) it.func = FUNC_COMPLETE;
        else if (w < 80) it.func = FUNC_UPDATE;
        else if (w < 90) it.func = FUNC_ABORT;
        else if (w < 97) it.func = FUNC_QUERY;
        else it.func = FUNC_BITS'($urandom_range(7, 6));
        // mostly a small key pool so keys collide
        if ($urandom_range(7) == 0) begin
            it.model_id = $urandom;
            it.node_id = $urandom;
        end else begin
            it.model_id = $urandom_range(3);
            it.node_id = $urandom_range(15);
        end
        if ($urandom_range(3) == 0) it.priority_req = $urandom_range(4) - 2;
        else it.priority_req = $urandom;
        return it;
    endfunction

    // result checking
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item out: %p", o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result.done_flag !== want.done_flag
                    || o_result.job_valid !== want.job_valid
                    || o_result.job_model !== want.job_model
                    || o_result.job_node !== want.job_node
                    || o_result.job_priority !== want.job_priority
                    || o_result.index_status !== want.index_status
                    || o_result.job_count !== want.job_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, o_result);
                end
            end
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_item it;
        int    nfill;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = MODE_NEVER;
        i_rst_n = 1'b0;
        mismatches = 0;
        stall_cycles = 0;
        cur_mode = MODE_NEVER;
        job_cnt = 0;
        for (int k = 0; k < KEY_DEPTH; k++) begin
            key_vld[k] = 1'b0; key_pnd[k] = 1'b0; key_pos[k] = 0;
        end
        for (int s = 0; s < HEAP_DEPTH; s++) job_kix[s] = 0;

        // directed rows, mode never after reset
        add_row(mk_item(FUNC_QUERY, 8'd0, 32'd0, 32'd0), 1, mk_res(0, 0, 0, 0, 0, STAT_NONE, 0));
        add_row(mk_item(FUNC_TAKE, 8'd0, 32'd0, 32'd0), 1, mk_res(0, 0, 0, 0, 0, STAT_NONE, 0));
        add_row(mk_item(3'd6, 8'hff, 32'hffffffff, 32'hffffffff), 1,
                mk_res(0, 0, 0, 0, 0, STAT_NONE, 0));
        add_row(mk_item(3'd7, 8'd0, 32'd0, 32'd0), 1, mk_res(0, 0, 0, 0, 0, STAT_NONE, 0));
        add_row(mk_item(FUNC_PUSH, 8'hff, 32'hffffffff, 32'h7fffffff), 1,
                mk_res(1, 0, 0, 0, 0, STAT_NONE, 1));
        add_row(mk_item(FUNC_PUSH, 8'd0, 32'd0, 32'h80000000), 1,
                mk_res(1, 0, 0, 0, 0, STAT_NONE, 2));
        add_row(mk_item(FUNC_PUSH, 8'hff, 32'hffffffff, 32'd0), 1,
                mk_res(0, 0, 0, 0, 0, STAT_NONE, 2));
        add_row(mk_item(FUNC_QUERY, 8'hff, 32'hffffffff, 32'd0), 1,
                mk_res(0, 0, 0, 0, 0, STAT_LOADING, 2));
        add_row(mk_item(FUNC_UPDATE, 8'd0, 32'd0, 32'd5), 1, mk_res(0, 0, 0, 0, 0, STAT_NONE, 2));
        add_row(mk_item(FUNC_ABORT, 8'd0, 32'd0, 32'd0), 1, mk_res(0, 0, 0, 0, 0, STAT_NONE, 2));
        add_row(mk_item(FUNC_TAKE, 8'd0, 32'd0, 32'd0), 1,
                mk_res(0, 1, 8'hff, 32'hffffffff, 32'h7fffffff, STAT_NONE, 1));
        add_row(mk_item(FUNC_COMPLETE, 8'hff, 32'hffffffff, 32'd0), 0, '0);
        add_cfg(MODE_ANY);
        add_row(mk_item(FUNC_PUSH, 8'd1, 32'd7, 32'd100), 0, '0);
        add_row(mk_item(FUNC_PUSH, 8'd1, 32'd8, 32'd100), 0, '0);
        add_row(mk_item(FUNC_TAKE, 8'd0, 32'd0, 32'd0), 0, '0);
        add_row(mk_item(FUNC_UPDATE, 8'd0, 32'd0, 32'd200), 0, '0);
        add_row(mk_item(FUNC_QUERY, 8'd1, 32'd8, 32'd0), 0, '0);
        add_row(mk_item(FUNC_QUERY, 8'd0, 32'd0, 32'd0), 0, '0);
        add_row(mk_item(FUNC_ABORT, 8'd0, 32'd0, 32'd0), 0, '0);
        add_cfg(MODE_DEC);
        add_row(mk_item(FUNC_UPDATE, 8'd1, 32'd7, 32'd50), 0, '0);
        add_row(mk_item(FUNC_UPDATE, 8'd1, 32'd7, 32'd60), 0, '0);
        add_cfg(MODE_INC);
        add_row(mk_item(FUNC_UPDATE, 8'd1, 32'd7, 32'd70), 0, '0);
        add_row(mk_item(FUNC_COMPLETE, 8'd1, 32'd8, 32'd0), 0, '0);
        add_row(mk_item(FUNC_QUERY, 8'd1, 32'd8, 32'd0), 0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) write_mode(dir_rows[i].mode);
            else send_item(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp);
            maybe_idle(1);
        end

        // fill the heap, then the key store, with random priorities
        write_mode(MODE_ANY);
        nfill = 0;
        for (int i = 0; i < 68; i++) begin
            send(mk_item(FUNC_PUSH, 8'h5a, 32'(i), $urandom));
            maybe_idle(1);
        end
        for (int i = 0; i < 40; i++) begin
            send(mk_item(FUNC_TAKE, 8'd0, 32'd0, 32'd0));
            maybe_idle(1);
        end
        for (int i = 0; i < 34; i++) begin
            send(mk_item(FUNC_PUSH, 8'ha5, 32'(i), $urandom));
            maybe_idle(1);
        end
        send(mk_item(FUNC_TAKE, 8'd0, 32'd0, 32'd0));
        // hold off until the queue has caught up
        start <= 1'b0;
        wait_empty();
        for (int i = 0; i < 68; i++) begin
            send(mk_item(FUNC_COMPLETE, 8'h5a, 32'(i), 32'd0));
            maybe_idle(1);
        end
        for (int i = 0; i < 34; i++) begin
            send(mk_item(FUNC_COMPLETE, 8'ha5, 32'(i), 32'd0));
            maybe_idle(1);
        end
        while (job_cnt > 0 && nfill < 200) begin
            send(mk_item(FUNC_TAKE, 8'd0, 32'd0, 32'd0));
            it = mk_item(FUNC_COMPLETE, last_pred.job_model, last_pred.job_node, 32'd0);
            send(it);
            nfill++;
            maybe_idle(1);
        end

        // random traffic over every mode, last stretch without gaps
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_mode(MODE_ANY);
                1: write_mode(MODE_DEC);
                2: write_mode(MODE_INC);
                3: write_mode(MODE_NEVER);
                default: write_mode(MODE_ANY);
            endcase
            for (int i = 0; i < 32; i++) begin
                send(random_item());
                maybe_idle(ph < 4);
            end
        end

        start <= 1'b0;
        wait_empty();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
